// File: src/lgs_pkg.sv
// Shared constants, register indexes and the B3/S23 rule for the life generation stream.
package lgs_pkg;

    localparam int MAX_COLS_DEF    = 128;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int GRID_WIDTH_RST  = 100;
    localparam int GRID_HEIGHT_RST = 60;
    localparam int DIM_MIN         = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int HEIGHT_W   = 7;
    localparam int OUT_ROW_W  = 6;
    localparam int OUT_COL_W  = 7;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Next state of the center cell of a 3x3 window (center at bit 4).
    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                cnt = cnt + 4'(win[i]);
            end
        end
        return (cnt == 4'd3) || (win[4] && (cnt == 4'd2));
    endfunction

endpackage

// File: src/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/lgs_pos_div.sv
// Restoring divider, one quotient bit per cycle: splits a linear position into row and column.
module lgs_pos_div #(
    parameter int DVD_W = 13,
    parameter int DVS_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit; subtract when it fits.
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_next = {quo_reg[DVD_W-2:0], fits};
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: src/lgs_window.sv
// 3x3 neighbour window: shifts in one column per cell and applies the life rule.
module lgs_window
    import lgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  logic up2,
    input  logic up1,
    input  logic cell_bit,
    output logic next_alive
);

    logic [8:0] window_reg, window_next;

    // Oldest row in bits 2:0, newest column in bit 0 of each row.
    assign window_next = {window_reg[7:6], cell_bit,
                          window_reg[4:3], up1,
                          window_reg[1:0], up2};

    assign next_alive = life_rule(window_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift)
        begin
            window_reg <= window_next;
        end
    end

endmodule

// File: src/life_generation_stream.sv
// Top level of the streaming Game of Life (B3/S23) generation engine.
//
// Cells of one generation enter in row-major raster order, one per transaction on the
// s_axis side (tdata[0] = alive bit, tuser = pad flag). Each cell is answered one grid
// row plus one cell later on the m_axis side with its next-generation state, row and
// column; tlast marks the last cell of the generation. Border cells are always reported
// dead. After the last cell of a frame, W+1 results are still owed: send pad
// transactions to drain them, or start the next frame, whose first W+1 cells each also
// push out one owed result. A pad with nothing owed is absorbed without a result.
// Throughput is one transaction per clock: the two previous rows sit in a 2-bit-wide
// line RAM read ahead at the column the next cell will use, a 3x3 window register
// feeds the rule, and a single output register takes the result, so input and output
// stall only when that register is full and not being taken; input also stalls while
// a register write is handled. grid_width (index 0) and grid_height (index 1) are
// clamped to 3..MAX_COLS and 3..MAX_ROWS; write them only while the block is idle.
// After each write the block holds both ready signals low while it starts a restoring
// divider (ST_NORM), remaps the pending output position to row and column at one
// quotient bit per cycle (ST_DIV), and loads the result. An input or output position
// that falls outside the new grid restarts at zero with the next transaction.
// Line RAM columns never written since reset read as dead cells.
module life_generation_stream
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Cell input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] cell_alive, [7:1] zero
    input  logic                  s_axis_tuser,   // [0] pad
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] next_alive, [6:1] out_row,
                                                  // [13:7] out_col, [15:14] zero
    output logic                  m_axis_tlast,   // frame_last
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WD_W  = $clog2(MAX_COLS + 1);
    localparam int HT_W  = $clog2(MAX_ROWS + 1);
    localparam int POS_W = $clog2(MAX_COLS * MAX_ROWS);
    localparam int WD_RST = (GRID_WIDTH_RST > MAX_COLS) ? MAX_COLS : GRID_WIDTH_RST;
    localparam int HT_RST = (GRID_HEIGHT_RST > MAX_ROWS) ? MAX_ROWS : GRID_HEIGHT_RST;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_NORM,
        ST_DIV
    } state_t;

    state_t           state_reg, state_next;
    logic [WD_W-1:0]  wd_reg, wd_next;
    logic [HT_W-1:0]  ht_reg, ht_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_alive_reg, out_alive_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             out_last_reg, out_last_next;
    logic [MAX_COLS-1:0] col_valid_reg, col_valid_next;
    logic             valid_rd_reg;

    logic             in_acc;
    logic             cfg_acc;
    logic             cell_bit;
    logic             pad;
    logic             late;
    logic             emit;
    logic             use_window;
    logic             owed;
    logic             inner;
    logic             frame_end;
    logic [WD_W-1:0]  wd_cfg;
    logic [HT_W-1:0]  ht_cfg;
    logic [HEIGHT_W-1:0] ht_raw;
    logic [31:0]      total;
    logic [POS_W-1:0] pos_norm;
    logic             in_over;
    logic             pos_over;
    logic [COL_W-1:0] in_col_eff;
    logic [ROW_W-1:0] in_row_eff;
    logic [COL_W-1:0] ocol_eff;
    logic [ROW_W-1:0] orow_eff;
    logic [COL_W-1:0] rd_col;
    logic             div_start;
    logic             div_done;
    logic [POS_W-1:0] div_quo;
    logic [WD_W-1:0]  div_rem;
    logic [1:0]       ram_rd;
    logic             up1;
    logic             up2;
    logic             win_alive;
    logic             line_wr;

    assign cell_bit = s_axis_tdata[0];
    assign pad    = s_axis_tuser;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    assign s_axis_tready = (state_reg == ST_RUN) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = (state_reg == ST_RUN);

    // Clamp incoming dimensions to the supported range.
    assign ht_raw = cfg_data[HEIGHT_W-1:0];
    always_comb
    begin
        if (32'(cfg_data) < DIM_MIN)
        begin
            wd_cfg = WD_W'(DIM_MIN);
        end
        else if (32'(cfg_data) > MAX_COLS)
        begin
            wd_cfg = WD_W'(MAX_COLS);
        end
        else
        begin
            wd_cfg = WD_W'(cfg_data);
        end
        if (32'(ht_raw) < DIM_MIN)
        begin
            ht_cfg = HT_W'(DIM_MIN);
        end
        else if (32'(ht_raw) > MAX_ROWS)
        begin
            ht_cfg = HT_W'(MAX_ROWS);
        end
        else
        begin
            ht_cfg = HT_W'(ht_raw);
        end
    end

    // Line RAM data; a column not yet written since reset reads as dead.
    assign up1 = valid_rd_reg & ram_rd[0];
    assign up2 = valid_rd_reg & ram_rd[1];
    assign line_wr = in_acc && !pad;

    // A position left outside the grid by a register write counts as zero; hold the raw
    // value until the next transaction commits the restart.
    assign in_over    = (32'(in_col_reg) >= 32'(wd_reg)) || (32'(in_row_reg) >= 32'(ht_reg));
    assign in_col_eff = in_over ? '0 : in_col_reg;
    assign in_row_eff = in_over ? '0 : in_row_reg;

    assign total    = 32'(wd_reg) * 32'(ht_reg);
    assign pos_over = (32'(pos_reg) >= total);
    assign pos_norm = pos_over ? '0 : pos_reg;
    assign ocol_eff = pos_over ? '0 : ocol_reg;
    assign orow_eff = pos_over ? '0 : orow_reg;
    assign div_start = (state_reg == ST_NORM);

    // Input position past the first W+1 cells of a generation.
    assign late = (32'(in_row_eff) >= 2) || ((in_row_eff == ROW_W'(1)) && (in_col_eff != '0));
    assign owed = (pos_norm != '0);
    assign use_window = !pad && late;
    assign emit = use_window || (!late && owed);
    assign inner = (orow_eff != '0) && (32'(orow_eff) + 2 <= 32'(ht_reg))
                && (ocol_eff != '0) && (32'(ocol_eff) + 2 <= 32'(wd_reg));
    assign frame_end = (32'(orow_eff) + 1 == 32'(ht_reg)) && (32'(ocol_eff) + 1 == 32'(wd_reg));

    // Fetch the column the next cell will use.
    assign rd_col = in_acc ? in_col_next : in_col_eff;

    always_comb
    begin
        state_next     = state_reg;
        wd_next        = wd_reg;
        ht_next        = ht_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_alive_next = out_alive_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        col_valid_next = col_valid_reg;

        // Drop the result once the sink takes it.
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (cfg_acc)
                begin
                    case (cfg_index)
                        REG_GRID_WIDTH:  wd_next = wd_cfg;
                        REG_GRID_HEIGHT: ht_next = ht_cfg;
                        default:         wd_next = wd_reg;
                    endcase
                    state_next = ST_NORM;
                end
                if (in_acc)
                begin
                    // Commit any pending restart of the positions.
                    in_col_next = in_col_eff;
                    in_row_next = in_row_eff;
                    pos_next    = pos_norm;
                    ocol_next   = ocol_eff;
                    orow_next   = orow_eff;
                    if (!pad)
                    begin
                        col_valid_next[in_col_eff] = 1'b1;
                        if (32'(in_col_eff) + 1 >= 32'(wd_reg))
                        begin
                            in_col_next = '0;
                            if (32'(in_row_eff) + 1 >= 32'(ht_reg))
                            begin
                                in_row_next = '0;
                            end
                            else
                            begin
                                in_row_next = in_row_eff + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            in_col_next = in_col_eff + COL_W'(1);
                        end
                    end
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_alive_next = use_window && inner && win_alive;
                        out_row_next   = orow_eff;
                        out_col_next   = ocol_eff;
                        out_last_next  = frame_end;
                        // Advance the output position, wrapping at the end of the frame.
                        if (frame_end)
                        begin
                            pos_next  = '0;
                            ocol_next = '0;
                            orow_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_norm + POS_W'(1);
                            if (32'(ocol_eff) + 1 == 32'(wd_reg))
                            begin
                                ocol_next = '0;
                                orow_next = orow_eff + ROW_W'(1);
                            end
                            else
                            begin
                                ocol_next = ocol_eff + COL_W'(1);
                            end
                        end
                    end
                end
            end
            ST_NORM:
            begin
                // Start the divider on the raw output position.
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    orow_next  = div_quo[ROW_W-1:0];
                    ocol_next  = div_rem[COL_W-1:0];
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            wd_reg        <= WD_W'(WD_RST);
            ht_reg        <= HT_W'(HT_RST);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            col_valid_reg <= '0;
            valid_rd_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wd_reg        <= wd_next;
            ht_reg        <= ht_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            ocol_reg      <= ocol_next;
            orow_reg      <= orow_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            col_valid_reg <= col_valid_next;
            // Follow the RAM read: fetch the column the next cell will use.
            valid_rd_reg  <= col_valid_reg[rd_col];
        end
    end

    always_ff @(posedge clk)
    begin
        out_alive_reg <= out_alive_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    // Two previous rows per column: bit 0 is the row above, bit 1 two rows above.
    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (in_col_eff),
        .wr_data ({up1, cell_bit}),
        .rd_addr (rd_col),
        .rd_data (ram_rd)
    );

    lgs_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (line_wr),
        .up2        (up2),
        .up1        (up1),
        .cell_bit   (cell_bit),
        .next_alive (win_alive)
    );

    lgs_pos_div #(
        .DVD_W (POS_W),
        .DVS_W (WD_W)
    ) u_pos_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (pos_reg),
        .divisor   (wd_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, OUT_COL_W'(out_col_reg), OUT_ROW_W'(out_row_reg),
                            out_alive_reg};

`ifndef ASSERT_OFF
    a_in_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=>
            ((32'(in_col_reg) < 32'(wd_reg)) && (32'(in_row_reg) < 32'(ht_reg))))
        else $error("input position outside the grid");

    a_out_pos_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && !pos_over) |->
            (32'(pos_reg) == 32'(orow_reg) * 32'(wd_reg) + 32'(ocol_reg)))
        else $error("output row and column disagree with linear position");

    a_late_cell_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !pad && late) |=> m_axis_tvalid)
        else $error("late cell produced no result");

    a_no_input_while_remap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> (!s_axis_tready && !cfg_ready))
        else $error("transaction accepted during position remap");
`endif

endmodule

// File: verif/life_result_checker.sv
// Result checker for the life generation stream: predicts each reported cell and compares.
`timescale 1ns / 100ps

module life_result_checker
    import lgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] cell_alive, [7:1] zero
    input  logic                  s_axis_tuser,   // [0] pad
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] next_alive, [6:1] out_row,
                                                  // [13:7] out_col, [15:14] zero
    input  logic                  m_axis_tlast,   // frame_last
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    results_owed
);

    typedef struct packed {
        logic                 next_alive;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } life_result_t;

    life_result_t next_gen_q[$];

    logic                  rows_back1 [MAX_COLS_DEF];
    logic                  rows_back2 [MAX_COLS_DEF];
    logic [8:0]            window;
    int                    in_row;
    int                    in_col;
    int                    out_pos;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    int                    err_total;

    function automatic int fit_dim(input int value, input int hi);
        if (value < DIM_MIN)
        begin
            return DIM_MIN;
        end
        return (value > hi) ? hi : value;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_total++;
        end
    endtask

    // Report the cell at out_pos and advance it; the window only counts for interior cells.
    task automatic report_cell(input bit use_window, input int wd, input int ht,
                               output life_result_t res);
        int   r;
        int   c;
        int   nbrs;
        logic alive_next;
        r = out_pos / wd;
        c = out_pos % wd;
        alive_next = 1'b0;
        if (use_window && r >= 1 && r <= ht - 2 && c >= 1 && c <= wd - 2)
        begin
            nbrs = $countones(window) - int'(window[4]);
            alive_next = (nbrs == 3) || (window[4] && nbrs == 2);
        end
        res.next_alive = alive_next;
        res.row = r[OUT_ROW_W-1:0];
        res.col = c[OUT_COL_W-1:0];
        res.last = (out_pos == wd * ht - 1);
        out_pos = (out_pos + 1 >= wd * ht) ? 0 : out_pos + 1;
    endtask

    task automatic predict_next_cell(input logic alive, input logic is_pad,
                                     output bit produced, output life_result_t res);
        int   wd;
        int   ht;
        bit   late;
        logic above1;
        logic above2;
        wd = fit_dim(int'(width_reg), MAX_COLS_DEF);
        ht = fit_dim(int'(height_reg), MAX_ROWS_DEF);
        produced = 1'b0;
        res = '0;
        if (in_col >= wd || in_row >= ht)
        begin
            in_col = 0;
            in_row = 0;
        end
        if (out_pos >= wd * ht)
        begin
            out_pos = 0;
        end
        late = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (is_pad)
        begin
            if (!late && out_pos != 0)
            begin
                report_cell(1'b0, wd, ht, res);
                produced = 1'b1;
            end
        end
        else
        begin
            above2 = rows_back2[in_col];
            above1 = rows_back1[in_col];
            window = {window[7:6], alive, window[4:3], above1, window[1:0], above2};
            rows_back2[in_col] = above1;
            rows_back1[in_col] = alive;
            in_col++;
            if (in_col >= wd)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= ht)
                begin
                    in_row = 0;
                end
            end
            if (late || out_pos != 0)
            begin
                report_cell(late, wd, ht, res);
                produced = 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        life_result_t got;
        life_result_t want;
        bit           produced;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_COLS_DEF; i++)
            begin
                rows_back1[i] = 1'b0;
                rows_back2[i] = 1'b0;
            end
            window = '0;
            in_row = 0;
            in_col = 0;
            out_pos = 0;
            width_reg = CFG_DATA_W'(GRID_WIDTH_RST);
            height_reg = HEIGHT_W'(GRID_HEIGHT_RST);
            err_total = 0;
            next_gen_q.delete();
            mismatches <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == REG_GRID_HEIGHT)
                begin
                    height_reg = cfg_data[HEIGHT_W-1:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.next_alive = m_axis_tdata[0];
                got.row = m_axis_tdata[OUT_ROW_W:1];
                got.col = m_axis_tdata[OUT_ROW_W+OUT_COL_W:OUT_ROW_W+1];
                got.last = m_axis_tlast;
                if (next_gen_q.size() == 0)
                begin
                    $error("unexpected result: row %0d col %0d alive %0d",
                           got.row, got.col, got.next_alive);
                    err_total++;
                end
                else
                begin
                    want = next_gen_q.pop_front();
                    check_field("next_alive", want.next_alive, got.next_alive);
                    check_field("out_row", want.row, got.row);
                    check_field("out_col", want.col, got.col);
                    check_field("frame_last", want.last, got.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_next_cell(s_axis_tdata[0], s_axis_tuser, produced, want);
                if (produced)
                begin
                    next_gen_q.push_back(want);
                end
            end
            results_owed <= next_gen_q.size();
            mismatches <= err_total;
        end
    end

endmodule

// File: verif/testbench.sv
// Stimulus top for the life generation stream: drives cells, pads and grid settings.
`timescale 1ns / 100ps

// The block turns a raster stream of alive bits into the next B3/S23 generation, one
// grid row plus one cell behind the input. This top only makes traffic and gives the
// verdict; life_result_checker sits beside the block, predicts every reported cell
// from the accepted transactions and counts mismatches.
//
// Flow:
//   - a short directed part on a 3x3 grid: a pad with nothing owed, a pad that lands
//     after the first W+1 cells, draining pads, a frame that starts while the previous
//     tail is still owed, a survivor and a birth at the only interior cell;
//   - random phases: each picks a grid (mostly small, sometimes the widest, the tallest,
//     or values outside 3..MAX that the block clamps), then sends whole frames with
//     random density, drained by pads or overlapped by the next frame, plus the odd
//     truncated frame or junk burst so that a later setting lands mid-frame.
// Grid registers are only written once every predicted result has come back and the
// block has had time to finish any pad-only work.
// Both sides draw a random idle gap before each transaction, with calm stretches of
// none, and the receiver holds off for a long stretch now and then so the output
// register fills and back-pressures the cell input.
module testbench;
    import lgs_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    // The block holds ready low during the remap after a register write; give a margin.
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [0] cell_alive, [7:1] zero
    logic                  s_axis_tuser;   // [0] pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] next_alive, [6:1] out_row,
                                           // [13:7] out_col, [15:14] zero
    logic                  m_axis_tlast;   // frame_last
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int results_owed;
    int src_calm;
    int sink_calm;
    int results_taken;
    int hold_at;
    int stall_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    life_generation_stream dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    life_result_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .results_owed  (results_owed)
    );

    // Grid size the block will use for a written value; only shapes the stimulus.
    function automatic int grid_dim(input int value, input int hi);
        if (value < DIM_MIN)
        begin
            return DIM_MIN;
        end
        return (value > hi) ? hi : value;
    endfunction

    // Offer one cell or pad transaction and hold it until the block takes it. tvalid
    // stays high on return, so the caller either offers the next one in the same step
    // or drops tvalid through settle_block.
    task automatic feed_cell(input logic alive, input logic is_pad);
        int gap;
        if (src_calm > 0)
        begin
            src_calm--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0)
            begin
                src_calm = $urandom_range(8, 40);
            end
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - 1){1'b0}}, alive};
        s_axis_tuser <= is_pad;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stop offering, wait for every predicted result, then let pad-only work finish.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both grid registers back to back; valid stays high between the two.
    task automatic program_grid(input logic [CFG_DATA_W-1:0] width_val,
                                input logic [CFG_DATA_W-1:0] height_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data <= width_val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data <= height_val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Result side: random idle per transaction, calm stretches, and long hold-offs.
    initial
    begin
        m_axis_tready <= 1'b0;
        sink_calm = 0;
        results_taken = 0;
        hold_at = 40;
        do @(posedge clk); while (!rst_n);
        forever
        begin : sink
            int gap;
            if (results_taken >= hold_at)
            begin
                // Hold off long enough for the output register to fill and stall input.
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(50, 80)) @(posedge clk);
                hold_at += 260;
            end
            if (sink_calm > 0)
            begin
                sink_calm--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                begin
                    sink_calm = $urandom_range(8, 40);
                end
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            results_taken++;
        end
    end

    // Watchdog: end the run when no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        // Row-major 3x3 frames, bit i = row * 3 + col.
        // Diagonal: the live center keeps exactly two neighbours and survives.
        logic [8:0] survivor_frame;
        // Dead center with exactly three live neighbours: a birth.
        logic [8:0] birth_frame;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] height_val;
        int  cells_fed;
        int  wd;
        int  ht;
        int  area;
        int  n_frames;
        int  kind;
        int  dens;
        int  len;
        bit  giant_done;
        survivor_frame = 9'b100010001;
        birth_frame = 9'b000100011;
        cells_fed = 0;
        giant_done = 1'b0;
        src_calm = 0;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Pad straight after reset: nothing is owed, so it is absorbed.
        feed_cell(1'b1, 1'b1);
        settle_block();
        program_grid(CFG_DATA_W'(DIM_MIN), CFG_DATA_W'(DIM_MIN));

        for (int i = 0; i < 9; i++)
        begin
            feed_cell(survivor_frame[i], 1'b0);
            // Pad past the first W+1 cells of a frame: ignored.
            if (i == 5)
            begin
                feed_cell(1'b1, 1'b0 | 1'b1);
            end
        end
        // Drain half of the owed tail, then let the next frame push out the rest.
        repeat (2) feed_cell(1'($urandom_range(0, 1)), 1'b1);
        for (int i = 0; i < 9; i++)
        begin
            feed_cell(birth_frame[i], 1'b0);
        end
        repeat (DIM_MIN + 1) feed_cell(1'($urandom_range(0, 1)), 1'b1);
        // Tail fully drained: this pad has nothing left to report.
        feed_cell(1'b0, 1'b1);

        while (cells_fed < RANDOM_ITEMS)
        begin
            settle_block();
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    // Widest rows, kept short.
                    case ($urandom_range(0, 3))
                        0: width_val = 8'd128;
                        1: width_val = 8'd129;
                        2: width_val = 8'd200;
                        default: width_val = 8'd255;
                    endcase
                    height_val = CFG_DATA_W'($urandom_range(0, 4));
                end
                2, 3:
                begin
                    // Tallest grids, kept narrow; bit 7 of height is dropped by the block.
                    case ($urandom_range(0, 3))
                        0: height_val = 8'd64;
                        1: height_val = 8'd65;
                        2: height_val = 8'd127;
                        default: height_val = 8'd255;
                    endcase
                    width_val = CFG_DATA_W'($urandom_range(0, 5));
                end
                4:
                begin
                    width_val = CFG_DATA_W'($urandom_range(0, 2));
                    height_val = CFG_DATA_W'($urandom_range(0, 2));
                end
                5:
                begin
                    if (!giant_done)
                    begin
                        width_val = 8'd255;
                        height_val = 8'd127;
                        giant_done = 1'b1;
                    end
                    else
                    begin
                        width_val = CFG_DATA_W'($urandom_range(3, 12));
                        height_val = CFG_DATA_W'($urandom_range(3, 8));
                    end
                end
                default:
                begin
                    width_val = CFG_DATA_W'($urandom_range(3, 12));
                    height_val = CFG_DATA_W'($urandom_range(3, 8));
                end
            endcase
            program_grid(width_val, height_val);
            wd = grid_dim(int'(width_val), MAX_COLS_DEF);
            ht = grid_dim(int'(height_val[HEIGHT_W-1:0]), MAX_ROWS_DEF);
            area = wd * ht;
            n_frames = (area > 200) ? 1 : $urandom_range(1, 3);

            for (int f = 0; f < n_frames; f++)
            begin
                kind = $urandom_range(0, 9);
                dens = $urandom_range(1, 7);
                if (kind == 0 || area > 1024)
                begin
                    // Truncated frame: the next setting then lands mid-frame. On the
                    // full-size grid, go deep enough to reach interior rows.
                    len = (area > 1024) ? $urandom_range(260, 400) : $urandom_range(1, area - 1);
                    repeat (len) feed_cell($urandom_range(0, 7) < dens, 1'b0);
                    cells_fed += len;
                    break;
                end
                if (kind == 1)
                begin
                    // Junk burst of cells and pads, not counted toward the item budget.
                    repeat ($urandom_range(1, 2 * wd))
                    begin
                        feed_cell(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                    continue;
                end
                repeat (area) feed_cell($urandom_range(0, 7) < dens, 1'b0);
                cells_fed += area;
                // Drain the tail with pads, or overlap it with the next frame.
                if (f == n_frames - 1 || $urandom_range(0, 1) == 1)
                begin
                    repeat (wd + 1) feed_cell(1'($urandom_range(0, 1)), 1'b1);
                    cells_fed += wd + 1;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        feed_cell(1'($urandom_range(0, 1)), 1'b1);
                    end
                end
            end
        end

        settle_block();
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
src/lgs_pkg.sv
src/lgs_ram.sv
src/lgs_pos_div.sv
src/lgs_window.sv
src/life_generation_stream.sv
verif/life_result_checker.sv
verif/testbench.sv
